// File: rtl/ogf_pkg.sv
package ogf_pkg;

	// Default map size in cells
	localparam int MAP_WIDTH_DEF  = 128;
	localparam int MAP_HEIGHT_DEF = 128;

	// Fixed-point layout
	localparam int ROT_FRAC = 14;
	localparam int POS_FRAC = 8;
	localparam int SUM_FRAC = 22;

	// Datapath widths, sized for maps up to 1024 cells a side
	localparam int OFS_W  = 12;
	localparam int LX_W   = 20;
	localparam int PROD_W = 36;
	localparam int SUM_W  = 40;
	localparam int CELL_W = 18;

	// Configuration port
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [REG_IDX_W-1:0] REG_COS    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POSE_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_POSE_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BLEND  = 3'd5;

	// Commands
	localparam logic CMD_FUSE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Cell values
	localparam logic [6:0]        CELL_UNKNOWN = 7'd50;
	localparam logic signed [7:0] VAL_FREE     = 8'sd0;
	localparam logic signed [7:0] VAL_OCC      = 8'sd100;
	localparam logic [8:0]        WEIGHT_FULL  = 9'd256;

	typedef struct packed {
		logic signed [15:0] cos_angle;
		logic signed [15:0] sin_angle;
		logic signed [15:0] pose_x;
		logic signed [15:0] pose_y;
		logic signed [15:0] sensor_offset;
	} cfg_t;

	typedef struct packed {
		logic              command;
		logic [6:0]        col;
		logic [6:0]        row;
		logic signed [7:0] local_value;
	} req_t;

	typedef struct packed {
		logic              command;
		logic signed [7:0] local_value;
		logic [6:0]        col;
		logic [6:0]        row;
		logic              out_of_range;
	} xf_t;

	typedef struct packed {
		logic [6:0] col;
		logic [6:0] row;
		logic [6:0] value;
		logic       written;
		logic       out_of_range;
	} res_t;

endpackage

// File: rtl/ogf_xform.sv
module ogf_xform #(
	parameter int MAP_WIDTH  = 128,
	parameter int MAP_HEIGHT = 128,
	localparam int ADDR_W    = $clog2(MAP_WIDTH * MAP_HEIGHT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ogf_pkg::req_t      req,
	input  ogf_pkg::cfg_t      cfg,
	output logic               done,
	output ogf_pkg::xf_t       xf,
	output logic [ADDR_W-1:0]  addr
);
	import ogf_pkg::*;

	localparam int XW = $clog2(MAP_WIDTH);
	localparam int YW = $clog2(MAP_HEIGHT);
	localparam logic signed [OFS_W-1:0] HALF_W = OFS_W'(MAP_WIDTH / 2);
	localparam logic signed [OFS_W-1:0] HALF_H = OFS_W'(MAP_HEIGHT / 2);
	localparam logic signed [SUM_W-1:0] CENTRE_X = SUM_W'(MAP_WIDTH / 2) << SUM_FRAC;
	localparam logic signed [SUM_W-1:0] CENTRE_Y = SUM_W'(MAP_HEIGHT / 2) << SUM_FRAC;
	localparam logic signed [CELL_W-1:0] LIM_X = CELL_W'(MAP_WIDTH);
	localparam logic signed [CELL_W-1:0] LIM_Y = CELL_W'(MAP_HEIGHT);

	// Truncate toward zero: floor, then step up for negative values with a fraction
	function automatic logic signed [CELL_W-1:0] trunc_cells(input logic signed [SUM_W-1:0] g);
		logic signed [SUM_W-1:0] fl;
		logic                    up;
		fl = g >>> SUM_FRAC;
		up = g[SUM_W-1] && (g[SUM_FRAC-1:0] != '0);
		return CELL_W'(fl) + signed'(CELL_W'(up));
	endfunction

	logic signed [OFS_W-1:0]  dx, dy;
	logic signed [LX_W-1:0]   lx, ly;
	logic signed [PROD_W-1:0] lxc_s1, lys_s1, lxs_s1, lyc_s1;
	req_t                     req_s1, req_s2;
	logic                     v_s1, v_s2, v_s3;
	logic signed [SUM_W-1:0]  gx, gy;
	logic signed [CELL_W-1:0] cx, cy, cx_s2, cy_s2;
	logic                     oor, oor_s2;
	xf_t                      xf_s3;
	logic [ADDR_W-1:0]        addr_s3;

	// Centre the local cell and shift it forward by the sensor offset
	always_comb begin
		dx = signed'(OFS_W'(req.col)) - HALF_W;
		dy = signed'(OFS_W'(req.row)) - HALF_H;
		lx = (LX_W'(dx) <<< POS_FRAC) + LX_W'(cfg.sensor_offset);
		ly = LX_W'(dy) <<< POS_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: rotation products
	always_ff @(posedge clk) begin
		if (start) begin
			lxc_s1 <= PROD_W'(lx) * PROD_W'(cfg.cos_angle);
			lys_s1 <= PROD_W'(ly) * PROD_W'(cfg.sin_angle);
			lxs_s1 <= PROD_W'(lx) * PROD_W'(cfg.sin_angle);
			lyc_s1 <= PROD_W'(ly) * PROD_W'(cfg.cos_angle);
			req_s1 <= req;
		end
	end

	// Stage 2: translate, truncate to cells (read commands keep their own cell), range check
	always_comb begin
		gx = SUM_W'(lxc_s1) + SUM_W'(lys_s1) + (SUM_W'(cfg.pose_x) <<< ROT_FRAC) + CENTRE_X;
		gy = SUM_W'(lyc_s1) - SUM_W'(lxs_s1) + (SUM_W'(cfg.pose_y) <<< ROT_FRAC) + CENTRE_Y;
		if (req_s1.command == CMD_READ) begin
			cx = signed'(CELL_W'(req_s1.col));
			cy = signed'(CELL_W'(req_s1.row));
		end else begin
			cx = trunc_cells(gx);
			cy = trunc_cells(gy);
		end
		oor = (cx < 0) || (cx >= LIM_X) || (cy < 0) || (cy >= LIM_Y);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			cx_s2  <= cx;
			cy_s2  <= cy;
			oor_s2 <= oor;
			req_s2 <= req_s1;
		end
	end

	// Stage 3: linear address
	always_ff @(posedge clk) begin
		if (v_s2) begin
			addr_s3 <= ADDR_W'(ADDR_W'(cy_s2[YW-1:0]) * ADDR_W'(MAP_WIDTH))
				+ ADDR_W'(cx_s2[XW-1:0]);
			xf_s3.command      <= req_s2.command;
			xf_s3.local_value  <= req_s2.local_value;
			xf_s3.col          <= cx_s2[6:0];
			xf_s3.row          <= cy_s2[6:0];
			xf_s3.out_of_range <= oor_s2;
		end
	end

	assign done = v_s3;
	assign xf   = xf_s3;
	assign addr = addr_s3;

endmodule

// File: rtl/ogf_grid.sv
module ogf_grid #(
	parameter int MAP_WIDTH  = 128,
	parameter int MAP_HEIGHT = 128,
	localparam int DEPTH     = MAP_WIDTH * MAP_HEIGHT,
	localparam int ADDR_W    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              access,
	input  ogf_pkg::xf_t      xf,
	input  logic [ADDR_W-1:0] addr,
	input  logic              commit,
	input  logic [8:0]        blend_weight,
	output logic              clearing,
	output ogf_pkg::res_t     res
);
	import ogf_pkg::*;

	logic [6:0]        mem [DEPTH];
	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;
	xf_t               xf_q;
	logic [ADDR_W-1:0] addr_q;
	logic [6:0]        rd_q;

	logic              fuse_ok;
	logic [8:0]        w;
	logic [16:0]       mix;
	logic [6:0]        blended;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [6:0]        wr_data;

	// Sweep every cell to unknown after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (access) begin
			xf_q   <= xf;
			addr_q <= addr;
			rd_q   <= mem[addr];
		end
	end

	always_comb begin
		fuse_ok = (xf_q.command == CMD_FUSE) && !xf_q.out_of_range
			&& ((xf_q.local_value == VAL_FREE) || (xf_q.local_value == VAL_OCC));
		w       = (blend_weight > WEIGHT_FULL) ? WEIGHT_FULL : blend_weight;
		mix     = 17'(16'(w) * 16'(rd_q)) + 17'(16'(WEIGHT_FULL - w) * 16'(xf_q.local_value[6:0]));
		blended = mix[14:8];
		wr_en   = clear_q || (commit && fuse_ok);
		wr_addr = clear_q ? clr_addr_q : addr_q;
		wr_data = clear_q ? CELL_UNKNOWN : blended;
		if (xf_q.out_of_range) begin
			res              = '0;
			res.out_of_range = 1'b1;
		end else begin
			res.col          = xf_q.col;
			res.row          = xf_q.row;
			res.value        = fuse_ok ? blended : rd_q;
			res.written      = fuse_ok;
			res.out_of_range = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign clearing = clear_q;

endmodule

// File: rtl/occupancy_grid_fusion_core.sv
// An accepted word passes three transform stages and a grid read, then is blended and written
// back as its result is loaded into the output register. Words are handled one at a time:
// a new word is accepted only after the last has committed, and a stalled output word delays
// that commit; the grid memory is read, blended and written back for one word at a time.
// Reset: registers return to their reset values, then a sweep writes unknown (50) to every
// grid cell while input words are held off; configuration writes are taken throughout.
module occupancy_grid_fusion_core #(
	parameter int MAP_WIDTH  = ogf_pkg::MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = ogf_pkg::MAP_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input word
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [6:0]                     col,
	input  logic [6:0]                     row,
	input  logic signed [7:0]              local_value,
	// result word
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [6:0]                     global_col,
	output logic [6:0]                     global_row,
	output logic [6:0]                     cell_value,
	output logic                           written,
	output logic                           out_of_range,
	// configuration
	input  logic                           cfg_we,
	input  logic [ogf_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [ogf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ogf_pkg::*;

	localparam int ADDR_W = $clog2(MAP_WIDTH * MAP_HEIGHT);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_XF   = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	logic [8:0]        blend_q;
	req_t              req;
	logic              accept;
	logic              commit;
	logic              xf_done;
	xf_t               xf;
	logic [ADDR_W-1:0] xf_addr;
	logic              clearing;
	res_t              res;
	res_t              res_q;
	logic              out_valid_q;

	// Configuration registers; the user must write them only while no word is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_angle     <= 16'sd16384;
			cfg_q.sin_angle     <= 16'sd0;
			cfg_q.pose_x        <= 16'sd0;
			cfg_q.pose_y        <= 16'sd0;
			cfg_q.sensor_offset <= 16'sd614;
			blend_q             <= 9'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS:    cfg_q.cos_angle     <= signed'(cfg_data);
				REG_SIN:    cfg_q.sin_angle     <= signed'(cfg_data);
				REG_POSE_X: cfg_q.pose_x        <= signed'(cfg_data);
				REG_POSE_Y: cfg_q.pose_y        <= signed'(cfg_data);
				REG_OFFSET: cfg_q.sensor_offset <= signed'(cfg_data);
				REG_BLEND:  blend_q             <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Take a new word only with the sequencer idle and the grid swept
	assign in_stall = (state_q != ST_IDLE) || clearing;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		req.command     = command;
		req.col         = col;
		req.row         = row;
		req.local_value = local_value;
	end

	// Commit the read-modify-write once the output register is free to take the result
	assign commit = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_XF;
				end
				ST_XF: begin
					if (xf_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pose transform and address generation
	ogf_xform #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.req    (req),
		.cfg    (cfg_q),
		.done   (xf_done),
		.xf     (xf),
		.addr   (xf_addr)
	);

	// Grid memory: read at the end of the transform, blend and write back at commit
	ogf_grid #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_grid (
		.clk          (clk),
		.arst_n       (arst_n),
		.access       (xf_done),
		.xf           (xf),
		.addr         (xf_addr),
		.commit       (commit),
		.blend_weight (blend_q),
		.clearing     (clearing),
		.res          (res)
	);

	// Output register: hold the word while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign global_col   = res_q.col;
	assign global_row   = res_q.row;
	assign cell_value   = res_q.value;
	assign written      = res_q.written;
	assign out_of_range = res_q.out_of_range;

	// A result appears only out of the commit state
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised without a commit");

	// No word is in flight or waiting while the grid is being swept
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (state_q == ST_IDLE) && !out_valid_q)
		else $error("word in flight during grid sweep");

	// The transform finishes only for the word the sequencer is waiting on
	a_xf_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		xf_done |-> state_q == ST_XF)
		else $error("transform done outside its state");

	// A cell outside the map is never reported as written
	a_oor_not_written: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.written && res_q.out_of_range))
		else $error("out-of-range cell reported as written");

endmodule

// File: test/occupancy_grid_fusion_core_test.sv
module occupancy_grid_fusion_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ogf_pkg::*;

	localparam int MAP_W = MAP_WIDTH_DEF;
	localparam int MAP_H = MAP_HEIGHT_DEF;
	localparam int HALF_W = MAP_W / 2;
	localparam int HALF_H = MAP_H / 2;
	localparam int RESET_CYCLES = 11;
	localparam int WORDS_PER_PHASE = 95;
	localparam int NUM_PHASES = 13;
	localparam int EXTREME_PHASES = 6;
	localparam int HIT_DEPTH = 64;
	// The grid sweep after reset holds the input off while every cell is written;
	// allow for that several times over, which dwarfs any gap or stall.
	localparam int IDLE_LIMIT = 4 * MAP_W * MAP_H + 4096;
	localparam int TAIL_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_FUSE;
	logic [6:0] col = '0;
	logic [6:0] row = '0;
	logic signed [7:0] local_value = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] global_col;
	logic [6:0] global_row;
	logic [6:0] cell_value;
	logic written;
	logic out_of_range;

	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	occupancy_grid_fusion_core i_dut (.*);

	always #6 clk = ~clk;

	// Shadow of the block: grid contents and the pose/blend registers.
	logic [6:0] grid_model [MAP_W*MAP_H];
	logic signed [15:0] cos_q = 16'sd16384;
	logic signed [15:0] sin_q = 16'sd0;
	logic signed [15:0] pose_x_q = 16'sd0;
	logic signed [15:0] pose_y_q = 16'sd0;
	logic signed [15:0] offset_q = 16'sd614;
	logic [8:0] blend_q = 9'd128;

	// Recently fused global cells, so that reads land on cells with history.
	logic [6:0] hit_col [HIT_DEPTH];
	logic [6:0] hit_row [HIT_DEPTH];
	int hit_count = 0;

	req_t pending_words[$];
	res_t expected_cells[$];
	int mismatches = 0;

	// Unit heading pairs, 14 fraction bits: axes, diagonals and a few odd angles.
	int rot_cos [12] = '{16384, 0, -16384, 0, 11585, 11585, -11585, -11585,
		15137, 6270, -15137, 14189};
	int rot_sin [12] = '{0, 16384, 0, -16384, 11585, -11585, 11585, -11585,
		6270, 15137, 6270, -8192};

	// Truncate a 22-fraction-bit position toward zero, so (-1, 0) maps to cell 0.
	function automatic longint to_cell(input longint g);
		if (g < 0)
			return -((-g) >> SUM_FRAC);
		return g >> SUM_FRAC;
	endfunction

	// Work out the result of one word and update the shadow grid.
	function automatic res_t predict_cell(input req_t w);
		longint lx, ly, gx, gy, cx, cy;
		int unsigned wt, lv, idx;
		res_t r = '0;
		if (w.command == CMD_FUSE) begin
			lx = (longint'(w.col) - HALF_W) * 256 + longint'(offset_q);
			ly = (longint'(w.row) - HALF_H) * 256;
			gx = lx * longint'(cos_q) + ly * longint'(sin_q)
				+ longint'(pose_x_q) * (64'sd1 << ROT_FRAC)
				+ longint'(HALF_W) * (64'sd1 << SUM_FRAC);
			gy = -lx * longint'(sin_q) + ly * longint'(cos_q)
				+ longint'(pose_y_q) * (64'sd1 << ROT_FRAC)
				+ longint'(HALF_H) * (64'sd1 << SUM_FRAC);
			cx = to_cell(gx);
			cy = to_cell(gy);
		end else begin
			cx = longint'(w.col);
			cy = longint'(w.row);
		end
		if (cx < 0 || cx >= MAP_W || cy < 0 || cy >= MAP_H) begin
			r.out_of_range = 1'b1;
			return r;
		end
		idx = int'(cy) * MAP_W + int'(cx);
		if (w.command == CMD_FUSE && (w.local_value == VAL_FREE || w.local_value == VAL_OCC)) begin
			// weight saturates at a full 256
			wt = (blend_q > WEIGHT_FULL) ? int'(WEIGHT_FULL) : int'(blend_q);
			lv = int'(w.local_value[6:0]);
			grid_model[idx] = 7'((wt * grid_model[idx] + (256 - wt) * lv) >> 8);
			r.written = 1'b1;
			hit_col[hit_count % HIT_DEPTH] = cx[6:0];
			hit_row[hit_count % HIT_DEPTH] = cy[6:0];
			hit_count++;
		end
		r.col = cx[6:0];
		r.row = cy[6:0];
		r.value = grid_model[idx];
		return r;
	endfunction

	// Sender: present queued words in bursts with random gaps; predict each
	// word at the edge that accepts it, and hold the payload while stalled.
	req_t issued_word = '0;
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_cells.push_back(predict_cell(issued_word));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					issued_word = pending_words.pop_front();
					in_valid <= 1'b1;
					command <= issued_word.command;
					col <= issued_word.col;
					row <= issued_word.row;
					local_value <= issued_word.local_value;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left = 0;
							3, 4, 5, 6, 7: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(5, 20);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each result word with the oldest prediction.
	task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	int stall_mode = 0;
	int stall_tick = 0;

	always @(posedge clk) begin
		res_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_cells.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					due = expected_cells.pop_front();
					check_field("global_col", due.col, global_col);
					check_field("global_row", due.row, global_row);
					check_field("cell_value", due.value, cell_value);
					check_field("written", 7'(due.written), 7'(written));
					check_field("out_of_range", 7'(due.out_of_range), 7'(out_of_range));
				end
			end
			// Periodically pick a new stall pattern at random: none, light, heavy, periodic.
			stall_tick++;
			if (stall_tick % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 7) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	// Watchdog: end the run once nothing has moved for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("occupancy_grid_fusion_core verification failed");
			$finish;
		end
	end

	task automatic queue_word(input logic cmd, input logic [6:0] c, input logic [6:0] r,
		input logic signed [7:0] v);
		pending_words.push_back('{command: cmd, col: c, row: r, local_value: v});
	endtask

	// Wait until every queued word is accepted and every result has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_cells.size() != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_COS: cos_q = data;
			REG_SIN: sin_q = data;
			REG_POSE_X: pose_x_q = data;
			REG_POSE_Y: pose_y_q = data;
			REG_OFFSET: offset_q = data;
			REG_BLEND: blend_q = data[8:0];
			default: ;
		endcase
	endtask

	// Load a full pose; junk the unused upper bits of the blend write.
	task automatic load_pose(input logic [15:0] cos_v, input logic [15:0] sin_v,
		input logic [15:0] px, input logic [15:0] py, input logic [15:0] ofs,
		input logic [8:0] wgt);
		write_reg(REG_COS, cos_v);
		write_reg(REG_SIN, sin_v);
		write_reg(REG_POSE_X, px);
		write_reg(REG_POSE_Y, py);
		write_reg(REG_OFFSET, ofs);
		write_reg(REG_BLEND, {7'($urandom()), wgt});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int pick;
		logic signed [7:0] v;
		for (int i = 0; i < MAP_W * MAP_H; i++)
			grid_model[i] = CELL_UNKNOWN;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset pose: a fuse of local (c, r) lands on global (c+2, r).
		queue_word(CMD_FUSE, 7'd0, 7'd0, VAL_OCC);
		queue_word(CMD_FUSE, 7'd0, 7'd0, VAL_OCC);
		queue_word(CMD_FUSE, 7'd0, 7'd0, VAL_FREE);
		queue_word(CMD_READ, 7'd2, 7'd0, 8'sd0);
		queue_word(CMD_FUSE, 7'd125, 7'd127, VAL_OCC);
		// pushed off the right-hand edge
		queue_word(CMD_FUSE, 7'd126, 7'd5, VAL_FREE);
		queue_word(CMD_FUSE, 7'd127, 7'd127, VAL_OCC);
		queue_word(CMD_FUSE, 7'd127, 7'd0, VAL_FREE);
		// values other than free or occupied address the cell but leave it alone
		queue_word(CMD_FUSE, 7'd10, 7'd10, 8'sd50);
		queue_word(CMD_FUSE, 7'd10, 7'd10, -8'sd128);
		queue_word(CMD_FUSE, 7'd10, 7'd10, 8'sd127);
		queue_word(CMD_FUSE, 7'd10, 7'd10, 8'sd101);
		queue_word(CMD_FUSE, 7'd10, 7'd10, -8'sd1);
		queue_word(CMD_FUSE, 7'd10, 7'd10, 8'sd99);
		queue_word(CMD_READ, 7'd0, 7'd0, 8'sd0);
		queue_word(CMD_READ, 7'd127, 7'd127, -8'sd1);
		queue_word(CMD_READ, 7'd127, 7'd0, 8'sd0);
		queue_word(CMD_READ, 7'd0, 7'd127, 8'sd0);
		queue_word(CMD_FUSE, 7'd64, 7'd64, VAL_FREE);
		queue_word(CMD_READ, 7'd66, 7'd64, 8'sd0);
		queue_word(CMD_FUSE, 7'd0, 7'd127, VAL_OCC);
		wait_drained();

		// Shift back by a fraction of a cell so that slightly negative positions
		// truncate toward zero onto cell 0; a full weight keeps the old value.
		load_pose(16'sd16384, 16'sd0, -16'sd700, -16'sd100, 16'sd614, 9'd256);
		queue_word(CMD_FUSE, 7'd0, 7'd0, VAL_OCC);
		queue_word(CMD_FUSE, 7'd1, 7'd1, VAL_FREE);
		queue_word(CMD_READ, 7'd0, 7'd0, 8'sd0);
		wait_drained();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// First the register extremes, then random poses.
			case (phase)
				0: load_pose(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd614, 9'd0);
				1: load_pose(16'sd0, 16'sd16384, 16'sd0, 16'h8000, 16'h8000, 9'd256);
				2: load_pose(-16'sd16384, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 9'd511);
				3: load_pose(16'sd0, -16'sd16384, 16'sd0, 16'h8000, 16'sd32767, 9'd300);
				4: load_pose(16'sd16384, 16'sd0, 16'h8000, 16'sd0, 16'sd32767, 9'd1);
				5: load_pose(16'sd0, 16'sd16384, 16'sd0, 16'sd32767, 16'sd32767, 9'd255);
				default: begin
					pick = $urandom_range(0, 15);
					load_pose(
						(pick < 12) ? 16'(rot_cos[pick]) : 16'($urandom_range(0, 32768) - 16384),
						(pick < 12) ? 16'(rot_sin[pick]) : 16'($urandom_range(0, 32768) - 16384),
						16'($urandom_range(0, 20480) - 10240),
						16'($urandom_range(0, 20480) - 10240),
						($urandom_range(0, 3) == 0) ? 16'($urandom())
							: 16'($urandom_range(0, 5120) - 2560),
						($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
							: 9'($urandom_range(0, 256)));
				end
			endcase
			if (phase < EXTREME_PHASES)
				pick = 0;

			repeat (WORDS_PER_PHASE) begin
				if ($urandom_range(0, 3) == 0) begin
					// reads: half of them revisit cells that were fused
					if (hit_count != 0 && $urandom_range(0, 1) == 1) begin
						pick = $urandom_range(0, ((hit_count < HIT_DEPTH) ? hit_count : HIT_DEPTH) - 1);
						queue_word(CMD_READ, hit_col[pick], hit_row[pick], 8'($urandom()));
					end else begin
						queue_word(CMD_READ, 7'($urandom()), 7'($urandom()), 8'($urandom()));
					end
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: v = VAL_FREE;
						4, 5, 6, 7, 8: v = VAL_OCC;
						default: v = 8'($urandom());
					endcase
					queue_word(CMD_FUSE, 7'($urandom()), 7'($urandom()), v);
				end
			end
			// hold the sender until every result of this pose is back
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_cells.size() == 0)
			$display("occupancy_grid_fusion_core verification clean");
		else
			$display("occupancy_grid_fusion_core verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/ogf_pkg.sv
rtl/ogf_xform.sv
rtl/ogf_grid.sv
rtl/occupancy_grid_fusion_core.sv
test/occupancy_grid_fusion_core_test.sv
